// ===== rtl/lpm_pkg.sv =====
// Shared types and constants of the IPv4 longest-prefix-match route table.
package lpm_pkg;

	localparam int ADDR_BITS = 32;
	localparam int LEN_W     = 6;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_BITS);

	typedef struct packed {
		logic                 valid;
		logic [LEN_W-1:0]     length;
		logic [ADDR_BITS-1:0] prefix;
		logic [ADDR_BITS-1:0] gateway;
	} route_entry_t;

	typedef struct packed {
		logic                 hit;
		logic [LEN_W-1:0]     length;
		logic [ADDR_BITS-1:0] gateway;
	} best_t;

	localparam int ENTRY_W = $bits(route_entry_t);

endpackage

// ===== rtl/lpm_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module lpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/lpm_best.sv =====
// Match test of one table entry and the running best-match register.
module lpm_best (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            clear,
	input  logic                            load,
	input  lpm_pkg::route_entry_t           entry,
	input  logic [lpm_pkg::ADDR_BITS-1:0]   dst,
	output lpm_pkg::best_t                  best
);
	import lpm_pkg::*;

	logic [ADDR_BITS-1:0] mask;
	logic                 take;
	logic                 hit_q;
	logic [LEN_W-1:0]     length_q;
	logic [ADDR_BITS-1:0] gateway_q;

	always_comb begin
		mask = {ADDR_BITS{1'b1}} << (MAX_LEN - entry.length);
		take = load && entry.valid && ((dst & mask) == entry.prefix)
			&& (!hit_q || (entry.length > length_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (clear) begin
			hit_q <= 1'b0;
		end else if (take) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			length_q  <= entry.length;
			gateway_q <= entry.gateway;
		end
	end

	assign best = '{hit: hit_q, length: length_q, gateway: gateway_q};

endmodule

// ===== rtl/ipv4_longest_prefix_match.sv =====
// Top level of the IPv4 longest-prefix-match route table.
//
// An item is taken when start is high and busy is low. Opcode write stores
// one entry (prefix, length saturated to 32, gateway, usable bit) at
// entry_index; slots at or above TABLE_DEPTH are ignored. Opcode lookup scans
// every slot in order and returns the longest usable match, the lowest slot
// winning a tie.
// Each item gives one result beat, shown with done high for exactly one cycle
// on found, gateway_out and matched_length; the receiver cannot stall it.
// A write beat appears the cycle after acceptance, with all fields zero, and
// busy stays low. A lookup reads the table memory one entry per cycle, holding
// busy high through the scan, drain and done states, and its beat is registered
// from the done state, after the registered memory read has drained.
// After reset the block sweeps the table once to clear every usable bit,
// holding busy high, so that no item is taken, until the last slot is cleared.
module ipv4_longest_prefix_match #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            opcode,
	input  logic [5:0]                      entry_index,
	input  logic [lpm_pkg::ADDR_BITS-1:0]   entry_prefix,
	input  logic [lpm_pkg::LEN_W-1:0]       entry_length,
	input  logic [lpm_pkg::ADDR_BITS-1:0]   entry_gateway,
	input  logic                            entry_usable,
	input  logic [lpm_pkg::ADDR_BITS-1:0]   lookup_address,
	output logic                            done,
	output logic                            found,
	output logic [lpm_pkg::ADDR_BITS-1:0]   gateway_out,
	output logic [lpm_pkg::LEN_W-1:0]       matched_length
);
	import lpm_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]           state_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 rvalid_s1;
	logic [ADDR_BITS-1:0] dst_q;
	logic                 done_q;
	logic                 found_q;
	logic [ADDR_BITS-1:0] gateway_q;
	logic [LEN_W-1:0]     length_q;

	logic                 accept;
	logic                 wr_item;
	logic                 in_range;
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	route_entry_t         wr_entry;
	logic [ENTRY_W-1:0]   ram_wdata;
	logic [ENTRY_W-1:0]   ram_rdata;
	route_entry_t         rd_entry;
	best_t                best;

	always_comb begin
		busy     = (state_q != ST_IDLE);
		accept   = start && !busy;
		wr_item  = accept && (opcode == OP_WRITE);
		in_range = ({7'd0, entry_index} < 13'(TABLE_DEPTH));
		wr_entry = '{
			valid:   entry_usable,
			length:  (entry_length > MAX_LEN) ? MAX_LEN : entry_length,
			prefix:  entry_prefix,
			gateway: entry_gateway
		};
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = idx_q;
			ram_wdata = '0;
		end else begin
			ram_we    = wr_item && in_range;
			ram_waddr = IDX_W'(entry_index);
			ram_wdata = wr_entry;
		end
		rd_entry = route_entry_t'(ram_rdata);
	end

	lpm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH),
		.AW    (IDX_W)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	lpm_best u_best (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (accept),
		.load   (rvalid_s1),
		.entry  (rd_entry),
		.dst    (dst_q),
		.best   (best)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			idx_q     <= '0;
			rvalid_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			rvalid_s1 <= (state_q == ST_SCAN);
			done_q    <= wr_item || (state_q == ST_DONE);
			unique case (state_q)
				ST_CLEAR: begin
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept && (opcode == OP_LOOKUP)) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dst_q <= lookup_address;
		end
		if (wr_item) begin
			found_q   <= 1'b0;
			gateway_q <= '0;
			length_q  <= '0;
		end else if (state_q == ST_DONE) begin
			found_q   <= best.hit;
			gateway_q <= best.hit ? best.gateway : '0;
			length_q  <= best.hit ? best.length : '0;
		end
	end

	assign done           = done_q;
	assign found          = found_q;
	assign gateway_out    = gateway_q;
	assign matched_length = length_q;

`ifndef SYNTHESIS
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_DONE || (start && !busy && opcode == OP_WRITE)))
		else $error("result beat without a finished item");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> (gateway_out == '0) && (matched_length == '0))
		else $error("result beat without a match carries non-zero fields");

	a_read_follows_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rvalid_s1 |-> $past(state_q == ST_SCAN))
		else $error("entry compared outside a table scan");

	a_length_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (matched_length <= MAX_LEN))
		else $error("matched length above the address width");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the IPv4 longest-prefix-match route table.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lpm_pkg::*;

	localparam int TABLE_DEPTH = 64;

	typedef struct {
		logic             op;
		bit [5:0]         idx;
		bit [ADDR_BITS-1:0] prefix;
		bit [LEN_W-1:0]   len;
		bit [ADDR_BITS-1:0] gw;
		bit               usable;
		bit [ADDR_BITS-1:0] addr;
	} route_cmd_t;

	typedef struct {
		bit               found;
		bit [ADDR_BITS-1:0] gw;
		bit [LEN_W-1:0]   len;
	} route_answer_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 opcode = OP_WRITE;
	logic [5:0]           entry_index = '0;
	logic [ADDR_BITS-1:0] entry_prefix = '0;
	logic [LEN_W-1:0]     entry_length = '0;
	logic [ADDR_BITS-1:0] entry_gateway = '0;
	logic                 entry_usable = 1'b0;
	logic [ADDR_BITS-1:0] lookup_address = '0;
	logic                 done;
	logic                 found;
	logic [ADDR_BITS-1:0] gateway_out;
	logic [LEN_W-1:0]     matched_length;

	bit [ADDR_BITS-1:0] shadow_prefix [TABLE_DEPTH];
	bit [LEN_W-1:0]     shadow_len [TABLE_DEPTH];
	bit [ADDR_BITS-1:0] shadow_gw [TABLE_DEPTH];
	bit                 shadow_used [TABLE_DEPTH];

	route_answer_t      awaited_answers [$];
	bit [ADDR_BITS-1:0] prefix_pool [4];
	int                 sender_idle_pct = 0;
	int                 errors = 0;

	ipv4_longest_prefix_match #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.entry_index(entry_index),
		.entry_prefix(entry_prefix),
		.entry_length(entry_length),
		.entry_gateway(entry_gateway),
		.entry_usable(entry_usable),
		.lookup_address(lookup_address),
		.done(done),
		.found(found),
		.gateway_out(gateway_out),
		.matched_length(matched_length)
	);

	always #5 clk = ~clk;

	function automatic bit [ADDR_BITS-1:0] net_mask(bit [LEN_W-1:0] len);
		if (len >= MAX_LEN)
			return '1;
		return ~(32'hFFFF_FFFF >> len);
	endfunction

	function automatic route_answer_t predict_route_answer(route_cmd_t c);
		route_answer_t r;
		r = '{default: '0};
		if (c.op == OP_WRITE) begin
			shadow_prefix[c.idx] = c.prefix;
			shadow_len[c.idx]    = (c.len > MAX_LEN) ? MAX_LEN : c.len;
			shadow_gw[c.idx]     = c.gw;
			shadow_used[c.idx]   = c.usable;
		end else begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (shadow_used[i] && !(r.found && shadow_len[i] <= r.len) &&
				    (c.addr & net_mask(shadow_len[i])) == shadow_prefix[i]) begin
					r.found = 1'b1;
					r.len   = shadow_len[i];
					r.gw    = shadow_gw[i];
				end
			end
		end
		return r;
	endfunction

	function automatic route_cmd_t write_cmd(bit [5:0] idx, bit [ADDR_BITS-1:0] prefix,
	                                         bit [LEN_W-1:0] len, bit [ADDR_BITS-1:0] gw,
	                                         bit usable);
		route_cmd_t c;
		c.op     = OP_WRITE;
		c.idx    = idx;
		c.prefix = prefix;
		c.len    = len;
		c.gw     = gw;
		c.usable = usable;
		c.addr   = $urandom;
		return c;
	endfunction

	function automatic route_cmd_t lookup_cmd(bit [ADDR_BITS-1:0] addr);
		route_cmd_t c;
		c.op     = OP_LOOKUP;
		c.idx    = 6'($urandom_range(0, 63));
		c.prefix = $urandom;
		c.len    = LEN_W'($urandom_range(0, 63));
		c.gw     = $urandom;
		c.usable = 1'($urandom_range(0, 1));
		c.addr   = addr;
		return c;
	endfunction

	// Presents one beat, optionally after a gap, and holds it until it is taken.
	task automatic send_item(route_cmd_t c);
		int gap;
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 4);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start          <= 1'b1;
		opcode         <= c.op;
		entry_index    <= c.idx;
		entry_prefix   <= c.prefix;
		entry_length   <= c.len;
		entry_gateway  <= c.gw;
		entry_usable   <= c.usable;
		lookup_address <= c.addr;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		awaited_answers.push_back(predict_route_answer(c));
	endtask

	always @(posedge clk) begin : check_answers
		route_answer_t want;
		if (arst_n && done === 1'b1) begin
			if (awaited_answers.size() == 0) begin
				$display("%0t: result beat with nothing expected: found=%0b gw=%h len=%0d",
				         $time, found, gateway_out, matched_length);
				errors++;
			end else begin
				want = awaited_answers.pop_front();
				if (found !== want.found) begin
					$display("%0t: found expected %0b, got %0b", $time, want.found, found);
					errors++;
				end
				if (gateway_out !== want.gw) begin
					$display("%0t: gateway_out expected %h, got %h", $time, want.gw,
					         gateway_out);
					errors++;
				end
				if (matched_length !== want.len) begin
					$display("%0t: matched_length expected %0d, got %0d", $time, want.len,
					         matched_length);
					errors++;
				end
			end
		end
	end

	task automatic test_empty_table();
		send_item(lookup_cmd(32'h0000_0000));
		send_item(lookup_cmd(32'hFFFF_FFFF));
	endtask

	task automatic test_route_extremes();
		send_item(write_cmd(6'd0, 32'h0000_0000, 6'd0, 32'h0A00_0001, 1'b1));
		send_item(write_cmd(6'd63, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 1'b1));
		send_item(lookup_cmd(32'hFFFF_FFFF));
		send_item(lookup_cmd(32'h1234_5678));
	endtask

	task automatic test_tie_break();
		send_item(write_cmd(6'd5, 32'h0A00_0000, 6'd8, 32'hAAAA_0005, 1'b1));
		send_item(write_cmd(6'd6, 32'h0A00_0000, 6'd8, 32'hBBBB_0006, 1'b1));
		send_item(write_cmd(6'd7, 32'h0A01_0000, 6'd16, 32'h0000_0000, 1'b1));
		send_item(write_cmd(6'd2, 32'h0A01_0200, 6'd24, 32'hCCCC_0002, 1'b0));
		send_item(lookup_cmd(32'h0A01_0203));
		send_item(lookup_cmd(32'h0AC8_0001));
	endtask

	task automatic test_odd_entries();
		send_item(write_cmd(6'd8, 32'hC0A8_0101, 6'd63, 32'h5555_5555, 1'b1));
		send_item(lookup_cmd(32'hC0A8_0101));
		send_item(write_cmd(6'd9, 32'hC0A8_0102, 6'd33, 32'h3333_3333, 1'b1));
		send_item(lookup_cmd(32'hC0A8_0102));
		send_item(write_cmd(6'd10, 32'hAC10_0001, 6'd12, 32'h7777_7777, 1'b1));
		send_item(lookup_cmd(32'hAC10_0001));
		send_item(write_cmd(6'd0, 32'h0000_0000, 6'd0, 32'h0A00_0001, 1'b0));
		send_item(lookup_cmd(32'h0102_0304));
	endtask

	// Nested routes are built from a few shared bases so that lookups see long chains.
	task automatic test_random_traffic(int count, int idle_pct);
		route_cmd_t c;
		bit [LEN_W-1:0] len;
		bit [ADDR_BITS-1:0] base;
		int slot;
		sender_idle_pct = idle_pct;
		foreach (prefix_pool[k])
			prefix_pool[k] = $urandom;
		repeat (count) begin
			if ($urandom_range(0, 99) < 40) begin
				len  = LEN_W'($urandom_range(0, 32));
				base = prefix_pool[$urandom_range(0, 3)];
				c = write_cmd(6'($urandom_range(0, 63)), base & net_mask(len), len,
				              $urandom, $urandom_range(0, 9) != 0);
				if ($urandom_range(0, 9) == 0)
					c.gw = '0;
				case ($urandom_range(0, 9))
					0: begin
						c.len    = LEN_W'($urandom_range(33, 63));
						c.prefix = base;
					end
					1: c.prefix = $urandom;
					default: ;
				endcase
			end else if ($urandom_range(0, 3) == 0) begin
				c = lookup_cmd($urandom);
			end else begin
				slot = $urandom_range(0, TABLE_DEPTH - 1);
				c = lookup_cmd(shadow_prefix[slot] | ($urandom & ~net_mask(shadow_len[slot])));
			end
			send_item(c);
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		sender_idle_pct = 34;
		test_empty_table();
		test_route_extremes();
		test_tie_break();
		test_odd_entries();
		test_random_traffic(277, 34);
		test_random_traffic(277, 48);
		test_random_traffic(276, 0);
		@(negedge clk);
		start <= 1'b0;
		while (awaited_answers.size() != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (errors == 0)
			$display("** ipv4_longest_prefix_match: PASSED **");
		else
			$display("** ipv4_longest_prefix_match: FAILED **");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d result beats outstanding.", awaited_answers.size());
		$display("** ipv4_longest_prefix_match: FAILED **");
		$finish;
	end

endmodule
